// File: rtl/checksummed_setpoint_frame_receiver_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef CHECKSUMMED_SETPOINT_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define CHECKSUMMED_SETPOINT_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Property checked on every clock edge, reset included.
`define CSFR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("csfr assertion failed");

// Property checked outside of reset only.
`define CSFR_ASSERT_RUN(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("csfr assertion failed");

`endif

// File: rtl/csfr_pkg.sv
`timescale 1ns / 1ps

package csfr_pkg;

   // frame layout
   localparam logic [7:0] START_BYTE  = 8'h24;
   localparam int         SUM_BYTES   = 8;
   localparam int         INDEX_W     = 4;
   localparam int         SLOT_W      = 3;
   localparam logic [INDEX_W-1:0] CHECK_INDEX = 4'd8;

   // one decoded setpoint frame
   typedef struct packed {
      logic [15:0] set_current;
      logic [15:0] set_voltage;
      logic [15:0] arc_voltage;
      logic [7:0]  weld_status;
      logic [7:0]  weld_mode;
   } csfr_result_type;

   // result handed from the parser to the output buffer
   typedef struct packed {
      logic            valid;
      csfr_result_type data;
   } csfr_push_type;

endpackage

// File: rtl/csfr_parser.sv
`timescale 1ns / 1ps

module csfr_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_accept,
   input  logic [7:0]             in_byte,
   output csfr_pkg::csfr_push_type push
);
   import csfr_pkg::*;

   logic                   in_frame_ff, in_frame_in;
   logic [INDEX_W-1:0]     index_ff, index_in;
   logic [7:0]             sum_ff, sum_in;
   logic [7:0]             store_ff [SUM_BYTES];
   logic                   store_we;
   logic                   match;

   // frame sequencing
   always_comb begin
      in_frame_in = in_frame_ff;
      index_in    = index_ff;
      sum_in      = sum_ff;
      store_we    = 1'b0;
      match       = 1'b0;
      if (in_accept) begin
         if (!in_frame_ff) begin
            if (in_byte == START_BYTE) begin
               in_frame_in = 1'b1;
               index_in    = '0;
               sum_in      = '0;
            end
         end else if (!index_ff[INDEX_W-1]) begin
            // payload byte: store and add
            store_we = 1'b1;
            sum_in   = sum_ff + in_byte;
            index_in = index_ff + 1'b1;
         end else begin
            // checksum byte closes the frame either way
            match       = (index_ff == CHECK_INDEX) && (in_byte == sum_ff);
            in_frame_in = 1'b0;
            index_in    = '0;
            sum_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         index_ff    <= '0;
         sum_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         index_ff    <= index_in;
         sum_ff      <= sum_in;
      end
   end

   // payload bytes, no reset needed
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[index_ff[SLOT_W-1:0]] <= in_byte;
      end
   end

   // little-endian words from the stored payload
   always_comb begin
      push.valid            = match;
      push.data.set_current = {store_ff[1], store_ff[0]};
      push.data.set_voltage = {store_ff[3], store_ff[2]};
      push.data.arc_voltage = {store_ff[5], store_ff[4]};
      push.data.weld_status = store_ff[6];
      push.data.weld_mode   = store_ff[7];
   end

endmodule

// File: rtl/csfr_out_buffer.sv
`timescale 1ns / 1ps

module csfr_out_buffer (
   input  logic                     clock,
   input  logic                     reset,
   input  csfr_pkg::csfr_push_type  push,
   input  logic                     out_stall,
   output logic                     out_valid,
   output csfr_pkg::csfr_result_type out_data,
   output logic                     full
);
   import csfr_pkg::*;

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   csfr_result_type main_ff, main_in;
   csfr_result_type skid_ff, skid_in;
   logic            pop;

   assign pop = main_valid_ff && !out_stall;

   // two-entry output buffer: main register plus skid
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = push.valid;
            skid_in       = push.data;
         end else begin
            main_valid_in = push.valid;
            main_in       = push.data;
         end
      end else if (push.valid) begin
         skid_valid_in = 1'b1;
         skid_in       = push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign full      = skid_valid_ff;

endmodule

// File: rtl/checksummed_setpoint_frame_receiver_unit.sv
`timescale 1ns / 1ps
// The checksum byte's transfer writes the result into the output buffer's main register, or its skid while one waits.
// Throughput: one byte per cycle while req_stall is low; a frame of ten bytes yields at most one result.
// req_stall rises only when two results wait in the output buffer.
// Synchronous reset closes any open frame, clears the sum and empties the buffer.

module checksummed_setpoint_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_set_current,
   output logic [15:0] rsp_set_voltage,
   output logic [15:0] rsp_arc_voltage,
   output logic [7:0]  rsp_weld_status,
   output logic [7:0]  rsp_weld_mode
);
   import csfr_pkg::*;

   logic            in_accept;
   logic            buf_full;
   csfr_push_type   push;
   csfr_result_type rsp_data;

   assign req_stall = buf_full;
   assign in_accept = req_valid && !req_stall;

   // frame parser
   csfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_byte   (req_rx_byte),
      .push      (push)
   );

   // result buffer
   csfr_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .full      (buf_full)
   );

   assign rsp_set_current = rsp_data.set_current;
   assign rsp_set_voltage = rsp_data.set_voltage;
   assign rsp_arc_voltage = rsp_data.arc_voltage;
   assign rsp_weld_status = rsp_data.weld_status;
   assign rsp_weld_mode   = rsp_data.weld_mode;

endmodule

// File: rtl/csfr_checker.sv
`timescale 1ns / 1ps
`include "checksummed_setpoint_frame_receiver_unit_defines.svh"

module csfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_set_current,
   input logic [15:0] rsp_set_voltage,
   input logic [15:0] rsp_arc_voltage,
   input logic [7:0]  rsp_weld_status,
   input logic [7:0]  rsp_weld_mode
);

   logic        req_xfer;
   logic [63:0] rsp_fields;

   assign req_xfer   = req_valid && !req_stall;
   assign rsp_fields = {rsp_set_current, rsp_set_voltage, rsp_arc_voltage,
                        rsp_weld_status, rsp_weld_mode};

   // reset leaves nothing to transfer
   `CSFR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // a new result only follows a byte transfer
   `CSFR_ASSERT_RUN(a_rise_needs_byte, clock, reset, $rose(rsp_valid) |-> $past(req_xfer))

   // input backpressure only while a result is already waiting
   `CSFR_ASSERT_RUN(a_stall_needs_result, clock, reset, req_stall |-> rsp_valid)

   // a stalled result holds
   `CSFR_ASSERT_RUN(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fields))

   // a stalled byte holds
   `CSFR_ASSERT_RUN(a_req_hold, clock, reset, req_valid && req_stall |=> req_valid && $stable(req_rx_byte))

endmodule

bind checksummed_setpoint_frame_receiver_unit csfr_checker u_csfr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_rx_byte     (req_rx_byte),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_set_current (rsp_set_current),
   .rsp_set_voltage (rsp_set_voltage),
   .rsp_arc_voltage (rsp_arc_voltage),
   .rsp_weld_status (rsp_weld_status),
   .rsp_weld_mode   (rsp_weld_mode)
);

// File: tb/checksummed_setpoint_frame_receiver_unit_test.sv
`timescale 1ns / 1ps

module checksummed_setpoint_frame_receiver_unit_test;
   import csfr_pkg::*;

   localparam int HALF_PERIOD      = 10;
   localparam int RESET_CYCLES     = 9;
   localparam int QUIET_LIMIT      = 2000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_BYTES     = 520;
   localparam int DRAIN_CYCLES     = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_set_current;
   logic [15:0] rsp_set_voltage;
   logic [15:0] rsp_arc_voltage;
   logic [7:0]  rsp_weld_status;
   logic [7:0]  rsp_weld_mode;

   // frame parser shadow state
   bit                 frame_open = 1'b0;
   logic [INDEX_W-1:0] frame_pos = '0;
   logic [7:0]         frame_sum = '0;
   logic [7:0]         frame_bytes [SUM_BYTES];

   csfr_result_type setpoint_queue [$];

   int error_count = 0;
   int used_bytes = 0;
   int quiet_cycles = 0;
   bit gaps_on = 1'b0;
   bit long_hold = 1'b0;

   checksummed_setpoint_frame_receiver_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_set_current (rsp_set_current),
      .rsp_set_voltage (rsp_set_voltage),
      .rsp_arc_voltage (rsp_arc_voltage),
      .rsp_weld_status (rsp_weld_status),
      .rsp_weld_mode   (rsp_weld_mode)
   );

   always #HALF_PERIOD clock = ~clock;

   // Advance the shadow parser by one byte; returns 0 when the byte is ignored.
   function automatic bit parse_rx_byte(input logic [7:0] b);
      csfr_result_type frame;
      if (!frame_open) begin
         if (b == START_BYTE) begin
            frame_open = 1'b1;
            frame_pos = '0;
            frame_sum = '0;
            return 1'b1;
         end
         return 1'b0;
      end
      if (frame_pos < SUM_BYTES) begin
         frame_bytes[frame_pos[SLOT_W-1:0]] = b;
         frame_sum = frame_sum + b;
         frame_pos = frame_pos + 1'b1;
         return 1'b1;
      end
      // checksum byte: emit on match, close the frame either way
      if (frame_pos == CHECK_INDEX && b == frame_sum) begin
         frame.set_current = {frame_bytes[1], frame_bytes[0]};
         frame.set_voltage = {frame_bytes[3], frame_bytes[2]};
         frame.arc_voltage = {frame_bytes[5], frame_bytes[4]};
         frame.weld_status = frame_bytes[6];
         frame.weld_mode   = frame_bytes[7];
         setpoint_queue.push_back(frame);
      end
      frame_open = 1'b0;
      frame_pos = '0;
      frame_sum = '0;
      return 1'b1;
   endfunction

   task automatic report_error(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_error($sformatf("%s got %h, expected %h", name, got, want));
   endtask

   // Compare each result transfer with the oldest pending setpoint.
   always @(posedge clock) begin
      csfr_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (setpoint_queue.size() == 0) begin
            report_error("result transfer with no frame pending");
         end else begin
            want = setpoint_queue.pop_front();
            check_field("set_current", rsp_set_current, want.set_current);
            check_field("set_voltage", rsp_set_voltage, want.set_voltage);
            check_field("arc_voltage", rsp_arc_voltage, want.arc_voltage);
            check_field("weld_status", {8'h00, rsp_weld_status}, {8'h00, want.weld_status});
            check_field("weld_mode", {8'h00, rsp_weld_mode}, {8'h00, want.weld_mode});
         end
      end
   end

   // Watchdog: too many cycles without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Result side: random stall bursts, or one long hold on request.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // One byte transfer, with an optional gap ahead of it.
   task automatic send_byte(input logic [7:0] b);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      if (parse_rx_byte(b)) used_bytes++;
   endtask

   // Drop valid and hold off until every pending setpoint has arrived.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (setpoint_queue.size() != 0);
   endtask

   function automatic logic [7:0] pick_payload_byte();
      case ($urandom_range(0, 7))
         0: return START_BYTE;
         1: return 8'h00;
         2: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Start byte, eight payload bytes, then a good or corrupted checksum.
   task automatic send_frame(input logic [7:0] data [SUM_BYTES], input bit good);
      logic [7:0] sum;
      sum = '0;
      send_byte(START_BYTE);
      for (int i = 0; i < SUM_BYTES; i++) begin
         sum = sum + data[i];
         send_byte(data[i]);
      end
      send_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
   endtask

   task automatic send_random_frame(input bit good);
      logic [7:0] data [SUM_BYTES];
      for (int i = 0; i < SUM_BYTES; i++) data[i] = pick_payload_byte();
      send_frame(data, good);
   endtask

   // Non-start bytes while idle are dropped.
   task automatic test_idle_noise();
      gaps_on = 1'b0;
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h25);
   endtask

   // Extremes and start bytes inside the payload.
   task automatic test_mixed_payload_frame();
      logic [7:0] data [SUM_BYTES];
      data = '{8'hFF, 8'h00, START_BYTE, 8'hFF, 8'h00, START_BYTE, 8'h80, 8'h7F};
      send_frame(data, 1'b1);
      wait_all_results();
   endtask

   // Checksum mismatch drops the frame.
   task automatic test_bad_checksum();
      send_random_frame(1'b0);
      send_random_frame(1'b1);
      wait_all_results();
   endtask

   // Long result stall: the output buffer fills and the input stalls.
   task automatic test_backpressure();
      gaps_on = 1'b0;
      long_hold = 1'b1;
      repeat (6) send_random_frame(1'b1);
      wait_all_results();
   endtask

   // Mostly well-formed frames, some corrupted, cut short or pure noise.
   task automatic test_random_traffic();
      int pick;
      used_bytes = 0;
      while (used_bytes < RANDOM_BYTES) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            send_random_frame($urandom_range(0, 5) != 0);
         end else if (pick < 9) begin
            send_byte(START_BYTE);
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         end
      end
      gaps_on = 1'b0;
      wait_all_results();
   endtask

   // Back-to-back frames with no gaps on either side.
   task automatic test_steady_stream();
      gaps_on = 1'b0;
      repeat (8) send_random_frame(1'b1);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_idle_noise();
      test_mixed_payload_frame();
      test_bad_checksum();
      test_backpressure();
      test_random_traffic();
      test_steady_stream();
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/csfr_pkg.sv
rtl/csfr_parser.sv
rtl/csfr_out_buffer.sv
rtl/checksummed_setpoint_frame_receiver_unit.sv
rtl/csfr_checker.sv
tb/checksummed_setpoint_frame_receiver_unit_test.sv
